// ===== rtl/udiv_pkg.sv =====
`timescale 1ns / 1ps

package udiv_pkg;

  // Operand and result geometry.
  localparam int unsigned DivBits  = 128;
  localparam int unsigned HalfBits = DivBits / 2;

  // Items the block can hold at once: input register, one register per
  // bit step, and two output slots.
  localparam int unsigned MaxInFlight = DivBits + 3;
  localparam int unsigned InFlightW   = $clog2(MaxInFlight + 1);

  // Payload carried down the bit-step pipeline. The dividend bits leave
  // nq at the top while quotient bits enter at the bottom.
  typedef struct packed {
    logic                 dbz;
    logic [DivBits-1:0]   nq;
    logic [DivBits-1:0]   rem;
    logic [DivBits-1:0]   dvs;
  } stage_t;

  // One finished result.
  typedef struct packed {
    logic [HalfBits-1:0]  quotient_high;
    logic [HalfBits-1:0]  quotient_low;
    logic [HalfBits-1:0]  remainder_high;
    logic [HalfBits-1:0]  remainder_low;
    logic                 divide_by_zero;
  } rsp_t;

endpackage

// ===== rtl/udiv_ifs.sv =====
`timescale 1ns / 1ps

interface udiv_req_if;
  logic                          valid;
  logic                          ready;
  logic [udiv_pkg::HalfBits-1:0] dividend_high;
  logic [udiv_pkg::HalfBits-1:0] dividend_low;
  logic [udiv_pkg::HalfBits-1:0] divisor_high;
  logic [udiv_pkg::HalfBits-1:0] divisor_low;

  modport source (
    output valid, dividend_high, dividend_low, divisor_high, divisor_low,
    input  ready
  );
  modport sink (
    input  valid, dividend_high, dividend_low, divisor_high, divisor_low,
    output ready
  );
endinterface

interface udiv_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [udiv_pkg::HalfBits-1:0] quotient_high;
  logic [udiv_pkg::HalfBits-1:0] quotient_low;
  logic [udiv_pkg::HalfBits-1:0] remainder_high;
  logic [udiv_pkg::HalfBits-1:0] remainder_low;
  logic                          divide_by_zero;

  modport source (
    output valid, quotient_high, quotient_low, remainder_high, remainder_low,
           divide_by_zero,
    input  ready
  );
  modport sink (
    input  valid, quotient_high, quotient_low, remainder_high, remainder_low,
           divide_by_zero,
    output ready
  );
endinterface

// ===== rtl/unsigned_divider_128.sv =====
// Path: a request passes through the input register, 128 bit steps and an
// output slot before its result can be taken. Throughput: one request per
// cycle while the pipeline moves; each bit step is one 129-bit subtract.
// Reset: rst_n is synchronous and active low; it empties the pipeline and the
// two-entry output queue, and the block accepts requests in the next cycle.
`timescale 1ns / 1ps

module unsigned_divider_128 (
  input  logic              clk,
  input  logic              rst_n,
  udiv_req_if.sink          in_req,
  udiv_rsp_if.source        out_rsp
);

  // The whole pipeline moves together. It stops only when the last bit step
  // holds a finished result and both output slots are taken; because the
  // queue has two slots, new requests still enter while one result waits.
  logic             en;
  logic             q_full;
  logic             in_vld_r;
  udiv_pkg::stage_t in_stage_r;
  udiv_pkg::stage_t in_stage_nxt;
  logic             vld_s   [0:udiv_pkg::DivBits];
  udiv_pkg::stage_t stage_s [0:udiv_pkg::DivBits];
  udiv_pkg::rsp_t   rsp_wr;
  udiv_pkg::rsp_t   rsp_rd;

  assign en           = !q_full || !vld_s[udiv_pkg::DivBits];
  assign in_req.ready = en;

  // Input register. The zero-divisor test is done here so that the bit
  // steps carry a single flag bit instead of the whole test.
  always_comb begin
    in_stage_nxt.nq  = {in_req.dividend_high, in_req.dividend_low};
    in_stage_nxt.dvs = {in_req.divisor_high, in_req.divisor_low};
    in_stage_nxt.rem = '0;
    in_stage_nxt.dbz = ({in_req.divisor_high, in_req.divisor_low} == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_req.valid) begin
      in_stage_r <= in_stage_nxt;
    end
  end

  assign vld_s[0]   = in_vld_r;
  assign stage_s[0] = in_stage_r;

  // One restoring step per stage, most significant dividend bit first.
  for (genvar g = 0; g < udiv_pkg::DivBits; g++) begin : g_step
    udiv_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (vld_s[g]),
      .in_stage  (stage_s[g]),
      .out_valid (vld_s[g+1]),
      .out_stage (stage_s[g+1])
    );
  end

  // With a zero divisor every step subtracts nothing, so the raw quotient
  // and remainder are meaningless; both are forced to zero instead.
  always_comb begin
    if (stage_s[udiv_pkg::DivBits].dbz) begin
      rsp_wr = '0;
    end else begin
      rsp_wr.quotient_high  = stage_s[udiv_pkg::DivBits].nq[udiv_pkg::DivBits-1:udiv_pkg::HalfBits];
      rsp_wr.quotient_low   = stage_s[udiv_pkg::DivBits].nq[udiv_pkg::HalfBits-1:0];
      rsp_wr.remainder_high = stage_s[udiv_pkg::DivBits].rem[udiv_pkg::DivBits-1:udiv_pkg::HalfBits];
      rsp_wr.remainder_low  = stage_s[udiv_pkg::DivBits].rem[udiv_pkg::HalfBits-1:0];
    end
    rsp_wr.divide_by_zero = stage_s[udiv_pkg::DivBits].dbz;
  end

  udiv_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (en && vld_s[udiv_pkg::DivBits]),
    .wr_data  (rsp_wr),
    .full     (q_full),
    .rd_valid (out_rsp.valid),
    .rd_ready (out_rsp.ready),
    .rd_data  (rsp_rd)
  );

  assign out_rsp.quotient_high  = rsp_rd.quotient_high;
  assign out_rsp.quotient_low   = rsp_rd.quotient_low;
  assign out_rsp.remainder_high = rsp_rd.remainder_high;
  assign out_rsp.remainder_low  = rsp_rd.remainder_low;
  assign out_rsp.divide_by_zero = rsp_rd.divide_by_zero;

endmodule

// ===== rtl/udiv_step.sv =====
`timescale 1ns / 1ps

module udiv_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  udiv_pkg::stage_t in_stage,
  output logic             out_valid,
  output udiv_pkg::stage_t out_stage
);

  logic [udiv_pkg::DivBits:0] part;
  logic [udiv_pkg::DivBits:0] diff;
  logic                       ge;
  udiv_pkg::stage_t           stage_nxt;
  logic                       valid_r;
  udiv_pkg::stage_t           stage_r;

  // The top bit of part is the carry out of the shift; a negative
  // difference means the partial remainder is below the divisor.
  always_comb begin
    part = {in_stage.rem, in_stage.nq[udiv_pkg::DivBits-1]};
    diff = part - {1'b0, in_stage.dvs};
    ge   = ~diff[udiv_pkg::DivBits];

    stage_nxt     = in_stage;
    stage_nxt.rem = ge ? diff[udiv_pkg::DivBits-1:0] : part[udiv_pkg::DivBits-1:0];
    stage_nxt.nq  = {in_stage.nq[udiv_pkg::DivBits-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

// ===== rtl/udiv_outq.sv =====
`timescale 1ns / 1ps

module udiv_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  udiv_pkg::rsp_t  wr_data,
  output logic            full,
  output logic            rd_valid,
  input  logic            rd_ready,
  output udiv_pkg::rsp_t  rd_data
);

  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;
  logic [1:0]     cnt_after;
  logic           pop;
  udiv_pkg::rsp_t head_r;
  udiv_pkg::rsp_t head_nxt;
  udiv_pkg::rsp_t tail_r;
  udiv_pkg::rsp_t tail_nxt;

  assign pop = rd_valid && rd_ready;

  // A push never arrives while both slots are occupied.
  always_comb begin
    cnt_after = cnt_r - {1'b0, pop};
    cnt_nxt   = cnt_after + {1'b0, push};
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (pop) begin
      head_nxt = tail_r;
    end
    if (push) begin
      if (cnt_after == 2'd0) begin
        head_nxt = wr_data;
      end else begin
        tail_nxt = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = head_r;

endmodule

// ===== rtl/udiv_checker.sv =====
`timescale 1ns / 1ps

module udiv_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [udiv_pkg::HalfBits-1:0] quotient_high,
  input logic [udiv_pkg::HalfBits-1:0] quotient_low,
  input logic [udiv_pkg::HalfBits-1:0] remainder_high,
  input logic [udiv_pkg::HalfBits-1:0] remainder_low,
  input logic                          divide_by_zero
);

  logic                           in_acc;
  logic                           out_acc;
  logic [udiv_pkg::InFlightW-1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + udiv_pkg::InFlightW'(in_acc) - udiv_pkg::InFlightW'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && divide_by_zero |->
      quotient_high == '0 && quotient_low == '0 &&
      remainder_high == '0 && remainder_low == '0)
    else $error("divide by zero result is not all zero");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != '0)
    else $error("result delivered with no request outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= udiv_pkg::InFlightW'(udiv_pkg::MaxInFlight))
    else $error("more requests outstanding than the pipeline holds");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result request shown right after reset");

endmodule

bind unsigned_divider_128 udiv_checker u_udiv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .quotient_high  (out_rsp.quotient_high),
  .quotient_low   (out_rsp.quotient_low),
  .remainder_high (out_rsp.remainder_high),
  .remainder_low  (out_rsp.remainder_low),
  .divide_by_zero (out_rsp.divide_by_zero)
);

// ===== sim/udiv_result_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the divider. Every accepted request is divided
// here and the answer is queued; every accepted response must match the
// oldest queued answer field by field.
module udiv_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  udiv_req_if         req_mon,
  udiv_rsp_if         rsp_mon,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  udiv_pkg::rsp_t pending_divisions[$];
  int unsigned    mismatches = 0;

  // Plain shift-and-subtract division with a 129-bit partial remainder.
  function automatic udiv_pkg::rsp_t divide_u128(
      input logic [udiv_pkg::DivBits-1:0] dividend,
      input logic [udiv_pkg::DivBits-1:0] divisor);
    logic [udiv_pkg::DivBits:0]   partial;
    logic [udiv_pkg::DivBits-1:0] quotient;
    udiv_pkg::rsp_t               res;
    res = '0;
    if (divisor == '0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    partial  = '0;
    quotient = '0;
    for (int i = udiv_pkg::DivBits - 1; i >= 0; i--) begin
      partial = {partial[udiv_pkg::DivBits-1:0], dividend[i]};
      if (partial >= {1'b0, divisor}) begin
        partial     = partial - {1'b0, divisor};
        quotient[i] = 1'b1;
      end
    end
    {res.quotient_high, res.quotient_low}   = quotient;
    {res.remainder_high, res.remainder_low} = partial[udiv_pkg::DivBits-1:0];
    return res;
  endfunction

  task automatic compare_field(input string name,
                               input logic [udiv_pkg::HalfBits-1:0] want,
                               input logic [udiv_pkg::HalfBits-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    udiv_pkg::rsp_t want;
    if (rst_n) begin
      if (req_mon.valid && req_mon.ready) begin
        pending_divisions.push_back(divide_u128(
          {req_mon.dividend_high, req_mon.dividend_low},
          {req_mon.divisor_high, req_mon.divisor_low}));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_divisions.size() == 0) begin
          $error("response with no request outstanding");
          mismatches++;
        end else begin
          want = pending_divisions.pop_front();
          compare_field("quotient_high", want.quotient_high, rsp_mon.quotient_high);
          compare_field("quotient_low", want.quotient_low, rsp_mon.quotient_low);
          compare_field("remainder_high", want.remainder_high, rsp_mon.remainder_high);
          compare_field("remainder_low", want.remainder_low, rsp_mon.remainder_low);
          compare_field("divide_by_zero", udiv_pkg::HalfBits'(want.divide_by_zero),
                        udiv_pkg::HalfBits'(rsp_mon.divide_by_zero));
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= pending_divisions.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Top of the divider testbench. It makes the requests, paces the response
// side, and gives the verdict. Result checking lives in udiv_result_checker.
module tb;

  // A run is cut short when no request and no response has been accepted
  // for this many cycles. The longest quiet stretch in a correct run is the
  // deliberate response hold below, which is far shorter.
  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned RandomCount  = 1450;
  // The long hold must outlast the pipeline depth so the input backs up.
  localparam int unsigned LongHold     = 400;
  localparam int unsigned BurstFirst   = 300;
  localparam int unsigned BurstLast    = 550;
  localparam int unsigned DrainPoint   = 900;

  localparam logic [udiv_pkg::HalfBits-1:0] AllOnes = '1;
  localparam logic [udiv_pkg::HalfBits-1:0] TopBit  = {1'b1, {(udiv_pkg::HalfBits-1){1'b0}}};

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned idle_cycles = 0;
  bit          long_hold_req   = 1'b0;
  bit          long_hold_taken = 1'b0;

  udiv_req_if req_ch();
  udiv_rsp_if rsp_ch();

  unsigned_divider_128 dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  udiv_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog: a hung block shows up as a long run of cycles in which
  // neither channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Response side. Ready alternates between runs of acceptance and stalls;
  // most stalls come from a short range and a few from a long one. Once, on request
  // from the stimulus, ready is held low for LongHold cycles so that the
  // pipeline fills and the block has to refuse new requests.
  initial begin
    int unsigned run_left;
    int unsigned stall_left;
    run_left   = 0;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        stall_left      = LongHold;
        run_left        = 0;
      end
      if (stall_left == 0 && run_left == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          run_left = $urandom_range(1, 40);
        end else if ($urandom_range(0, 99) < 85) begin
          stall_left = $urandom_range(1, 3);
        end else begin
          stall_left = $urandom_range(10, 60);
        end
      end
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        run_left--;
      end
    end
  end

  // Offer one request after 'gap' idle cycles and return at the edge that
  // accepts it. Valid stays high on return, so back-to-back requests never
  // drop it; the next call lowers it only if it has a gap to insert.
  task automatic offer_request(input logic [udiv_pkg::DivBits-1:0] dividend,
                               input logic [udiv_pkg::DivBits-1:0] divisor,
                               input int unsigned gap);
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    {req_ch.dividend_high, req_ch.dividend_low} <= dividend;
    {req_ch.divisor_high, req_ch.divisor_low}   <= divisor;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  function automatic logic [udiv_pkg::DivBits-1:0] rand_u128();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Operands of mixed magnitude: full width, shortened by a random shift,
  // with the top bit forced (the case where the shifted remainder needs a
  // carry bit), tiny, and single powers of two or all-ones runs.
  function automatic logic [udiv_pkg::DivBits-1:0] rand_operand();
    logic [udiv_pkg::DivBits-1:0] v;
    int unsigned                  kind;
    v    = rand_u128();
    kind = $urandom_range(0, 9);
    unique case (kind)
      4, 5, 6: begin
        v = v >> $urandom_range(1, udiv_pkg::DivBits - 1);
      end
      7: begin
        v[udiv_pkg::DivBits-1] = 1'b1;
      end
      8: begin
        v = v >> $urandom_range(udiv_pkg::DivBits - 16, udiv_pkg::DivBits - 1);
      end
      9: begin
        v = '0;
        v[$urandom_range(0, udiv_pkg::DivBits - 1)] = 1'b1;
        if ($urandom_range(0, 1) == 1) v = v - udiv_pkg::DivBits'(1);
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // Gaps between requests: mostly none, often short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    logic [udiv_pkg::DivBits-1:0] dividend;
    logic [udiv_pkg::DivBits-1:0] divisor;
    int unsigned                  r;

    rst_n                = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.dividend_high = '0;
    req_ch.dividend_low  = '0;
    req_ch.divisor_high  = '0;
    req_ch.divisor_low   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests. A zero divisor with several dividends, the
    // trivial divisors, equal and nearly equal operands, a dividend below
    // the divisor, and divisors at or above 2^127 where the partial
    // remainder overflows 128 bits during the shift.
    offer_request('0, '0, 0);
    offer_request({AllOnes, AllOnes}, '0, 0);
    offer_request(rand_u128(), '0, 0);
    offer_request('0, {64'd0, 64'd1}, 0);
    offer_request({AllOnes, AllOnes}, {64'd0, 64'd1}, 0);
    offer_request({AllOnes, AllOnes}, {AllOnes, AllOnes}, 0);
    offer_request({AllOnes, AllOnes - 64'd1}, {AllOnes, AllOnes}, 0);
    offer_request({64'd0, 64'd1}, {AllOnes, AllOnes}, 0);
    offer_request({AllOnes, AllOnes}, {TopBit, 64'd0}, 0);
    offer_request({TopBit, 64'd0}, {TopBit, 64'd0}, 0);
    offer_request({AllOnes, AllOnes}, {TopBit, 64'd1}, 0);
    offer_request({~TopBit, AllOnes}, {TopBit, 64'd0}, 0);
    offer_request({AllOnes, AllOnes}, {~TopBit, AllOnes}, 0);
    offer_request({AllOnes, AllOnes}, {64'd1, 64'd0}, 0);
    offer_request({AllOnes, AllOnes}, {64'd0, AllOnes}, 0);
    offer_request({AllOnes, 64'd0}, {AllOnes, 64'd0}, 0);
    offer_request({64'd1, 64'd0}, {64'd0, TopBit}, 0);
    offer_request({64'd0, AllOnes}, {64'd0, AllOnes}, 0);
    offer_request({64'd0, 64'd100}, {64'd0, 64'd7}, 0);
    offer_request({AllOnes, AllOnes}, {64'd0, 64'd3}, 0);
    offer_request({AllOnes, AllOnes}, {AllOnes, AllOnes - 64'd1}, 0);
    offer_request({TopBit, 64'd5}, {AllOnes, 64'd0}, 0);

    // Random requests. One stretch is sent back to back while the response
    // side holds off, and once the stimulus stops until every outstanding
    // request has been answered.
    for (int n = 0; n < RandomCount; n++) begin
      if (n == BurstFirst) long_hold_req = 1'b1;
      if (n == DrainPoint) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
      end
      dividend = rand_operand();
      r        = $urandom_range(0, 99);
      if (r < 4) begin
        divisor = '0;
      end else if (r < 10) begin
        divisor = dividend >> $urandom_range(0, 8);
      end else if (r < 14) begin
        divisor = dividend - udiv_pkg::DivBits'($urandom_range(0, 2))
                  + udiv_pkg::DivBits'($urandom_range(0, 2));
      end else begin
        divisor = rand_operand();
      end
      offer_request(dividend, divisor,
                    (n >= BurstFirst && n < BurstLast) ? 0 : pick_gap());
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Wait for every answer, then long enough for a stray extra response
    // to come out of the pipeline and be caught.
    while (pending_count != 0) @(posedge clk);
    repeat (udiv_pkg::DivBits + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/udiv_pkg.sv
rtl/udiv_ifs.sv
rtl/udiv_step.sv
rtl/udiv_outq.sv
rtl/unsigned_divider_128.sv
rtl/udiv_checker.sv
sim/udiv_result_checker.sv
sim/tb.sv
